>>> design/mscp_pkg.sv
// shared types, codes and the start code classifier for the start code parser
package mscp_pkg;

    // parse modes
    typedef enum logic [1:0] {
        MODE_SCAN = 2'd0,
        MODE_SEQ  = 2'd1,
        MODE_PIC  = 2'd2
    } parse_mode_t;

    // unit classes as reported on the result word
    localparam logic [2:0] CLS_PACK     = 3'd0;
    localparam logic [2:0] CLS_SYSTEM   = 3'd1;
    localparam logic [2:0] CLS_GOP      = 3'd2;
    localparam logic [2:0] CLS_SEQUENCE = 3'd3;
    localparam logic [2:0] CLS_PICTURE  = 3'd4;
    localparam logic [2:0] CLS_SLICE    = 3'd5;
    localparam logic [2:0] CLS_VIDEO    = 3'd6;
    localparam logic [2:0] CLS_AUDIO    = 3'd7;

    // start code values and ranges
    localparam logic [23:0] PREFIX_CODE   = 24'h000001;
    localparam logic [7:0]  CODE_SEQUENCE = 8'hB3;
    localparam logic [7:0]  CODE_PICTURE  = 8'h00;
    localparam logic [7:0]  CODE_PACK     = 8'hBA;
    localparam logic [7:0]  CODE_SYSTEM   = 8'hBB;
    localparam logic [7:0]  CODE_GOP      = 8'hB8;
    localparam logic [7:0]  SLICE_LAST    = 8'hAF;
    localparam logic [7:0]  AUDIO_FIRST   = 8'hC0;
    localparam logic [7:0]  AUDIO_LAST    = 8'hDF;
    localparam logic [7:0]  VIDEO_FIRST   = 8'hE0;
    localparam logic [7:0]  VIDEO_LAST    = 8'hEF;

    // window holds three bytes when full
    localparam logic [1:0] WINDOW_FULL = 2'd3;
    // last header byte index for each header kind
    localparam logic [1:0] SEQ_LAST_FIELD = 2'd3;
    localparam logic [1:0] PIC_LAST_FIELD = 2'd1;

    // one result word
    typedef struct packed {
        logic [7:0]  start_code;
        logic [2:0]  unit_class;
        logic [11:0] frame_width;
        logic [11:0] frame_height;
        logic [3:0]  rate_code;
        logic [2:0]  coding_type;
    } result_t;

    // class of a code that reports at once; bit 3 flags a known class
    function automatic logic [3:0] classify_code(input logic [7:0] code);
        logic [3:0] res;
        res = 4'd0;
        if (code == CODE_PACK)
            res = {1'b1, CLS_PACK};
        else if (code == CODE_SYSTEM)
            res = {1'b1, CLS_SYSTEM};
        else if (code == CODE_GOP)
            res = {1'b1, CLS_GOP};
        else if (code != CODE_PICTURE && code <= SLICE_LAST)
            res = {1'b1, CLS_SLICE};
        else if (code >= AUDIO_FIRST && code <= AUDIO_LAST)
            res = {1'b1, CLS_AUDIO};
        else if (code >= VIDEO_FIRST && code <= VIDEO_LAST)
            res = {1'b1, CLS_VIDEO};
        return res;
    endfunction

endpackage

>>> design/mpeg_start_code_parser_unit.sv
// top level of the mpeg start code parser: byte scanner, header capture, result skid
//
//   channel   direction  ports                                  meaning
//   s_        in         s_valid s_ready s_data_byte            one stream byte per word
//   m_        out        m_valid m_ready m_start_code ...       one classified start code
//
// one byte is taken per cycle while s_ready is high; the parse state updates at
// the accepting edge and a result is registered on m_, or in the skid register while
// m_ holds one not yet taken; a two-entry output (result plus skid register) sets
// the rate: bytes flow while one result waits; s_ready drops only when both hold
// aresetn is synchronous and active low; it empties the window and both output entries
module mpeg_start_code_parser_unit
    import mscp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_start_code,
    output logic [2:0]  m_unit_class,
    output logic [11:0] m_frame_width,
    output logic [11:0] m_frame_height,
    output logic [3:0]  m_rate_code,
    output logic [2:0]  m_coding_type
);

    // parse state
    parse_mode_t mode_reg, mode_next;
    logic [23:0] window_reg, window_next;
    logic [1:0]  fill_reg, fill_next;
    logic [1:0]  count_reg, count_next;
    logic [23:0] fields_reg, fields_next;
    logic [7:0]  held_reg, held_next;

    // output entries
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    logic    accept;
    logic    pop;
    logic    has_result;
    result_t new_result;
    logic [3:0] code_class;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;
    assign code_class = classify_code(s_data_byte);

    // parse one byte
    always_comb begin
        mode_next   = mode_reg;
        window_next = window_reg;
        fill_next   = fill_reg;
        count_next  = count_reg;
        fields_next = fields_reg;
        held_next   = held_reg;
        has_result  = 1'b0;
        new_result  = '0;
        unique case (mode_reg)
            MODE_SEQ: begin
                fields_next = {fields_reg[15:0], s_data_byte};
                count_next  = count_reg + 2'd1;
                if (count_reg == SEQ_LAST_FIELD) begin
                    has_result              = 1'b1;
                    new_result.start_code   = held_reg;
                    new_result.unit_class   = CLS_SEQUENCE;
                    new_result.frame_width  = {fields_reg[23:16], fields_reg[15:12]};
                    new_result.frame_height = {fields_reg[11:8], fields_reg[7:0]};
                    new_result.rate_code    = s_data_byte[3:0];
                    mode_next   = MODE_SCAN;
                    count_next  = '0;
                    fields_next = '0;
                end
            end
            MODE_PIC: begin
                fields_next = {fields_reg[15:0], s_data_byte};
                count_next  = count_reg + 2'd1;
                if (count_reg == PIC_LAST_FIELD) begin
                    has_result             = 1'b1;
                    new_result.start_code  = held_reg;
                    new_result.unit_class  = CLS_PICTURE;
                    new_result.coding_type = s_data_byte[5:3];
                    mode_next   = MODE_SCAN;
                    count_next  = '0;
                    fields_next = '0;
                end
            end
            default: begin
                mode_next = MODE_SCAN;
                if (fill_reg == WINDOW_FULL && window_reg == PREFIX_CODE) begin
                    window_next = '0;
                    fill_next   = '0;
                    held_next   = s_data_byte;
                    if (s_data_byte == CODE_SEQUENCE) begin
                        mode_next   = MODE_SEQ;
                        count_next  = '0;
                        fields_next = '0;
                    end else if (s_data_byte == CODE_PICTURE) begin
                        mode_next   = MODE_PIC;
                        count_next  = '0;
                        fields_next = '0;
                    end else begin
                        has_result            = code_class[3];
                        new_result.start_code = s_data_byte;
                        new_result.unit_class = code_class[2:0];
                    end
                end else begin
                    window_next = {window_reg[15:0], s_data_byte};
                    if (fill_reg != WINDOW_FULL)
                        fill_next = fill_reg + 2'd1;
                end
            end
        endcase
    end

    // result register and skid register
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (accept && has_result) begin
            if (!out_valid_reg || pop) begin
                out_next       = new_result;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = new_result;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_SCAN;
            window_reg     <= '0;
            fill_reg       <= '0;
            count_reg      <= '0;
            fields_reg     <= '0;
            held_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg   <= mode_next;
                window_reg <= window_next;
                fill_reg   <= fill_next;
                count_reg  <= count_next;
                fields_reg <= fields_next;
                held_reg   <= held_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_start_code   = out_reg.start_code;
    assign m_unit_class   = out_reg.unit_class;
    assign m_frame_width  = out_reg.frame_width;
    assign m_frame_height = out_reg.frame_height;
    assign m_rate_code    = out_reg.rate_code;
    assign m_coding_type  = out_reg.coding_type;

endmodule

>>> tb/tb.sv
// self-checking testbench for the mpeg start code parser unit
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mscp_pkg::*;

    // one stimulus byte, with a hand-written result where it is obvious
    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        result_t    want;
    } stim_row_t;

    localparam result_t NO_WORD = '0;
    localparam int DIR_ROWS = 26;
    localparam int RAND_BYTES = 950;
    localparam int QUIET_ROWS = 150;

    function automatic result_t mk_word(input logic [7:0] code, input logic [2:0] cls,
                                        input logic [11:0] w, input logic [11:0] h,
                                        input logic [3:0] rate, input logic [2:0] ctype);
        result_t r;
        r.start_code   = code;
        r.unit_class   = cls;
        r.frame_width  = w;
        r.frame_height = h;
        r.rate_code    = rate;
        r.coding_type  = ctype;
        return r;
    endfunction

    // directed part: all-ones sequence header, picture, pack, reserved code, audio edge
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'h01, 1'b0, NO_WORD},
        '{CODE_SEQUENCE, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD},
        '{8'hFF, 1'b1, mk_word(CODE_SEQUENCE, CLS_SEQUENCE, 12'hFFF, 12'hFFF, 4'hF, 3'd0)},
        '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'h01, 1'b0, NO_WORD},
        '{CODE_PICTURE, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD},
        '{8'hFF, 1'b1, mk_word(CODE_PICTURE, CLS_PICTURE, 12'd0, 12'd0, 4'd0, 3'd7)},
        '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'h01, 1'b0, NO_WORD},
        '{CODE_PACK, 1'b1, mk_word(CODE_PACK, CLS_PACK, 12'd0, 12'd0, 4'd0, 3'd0)},
        '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'h01, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'h01, 1'b0, NO_WORD},
        '{AUDIO_LAST, 1'b1, mk_word(AUDIO_LAST, CLS_AUDIO, 12'd0, 12'd0, 4'd0, 3'd0)}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_start_code;
    logic [2:0]  m_unit_class;
    logic [11:0] m_frame_width;
    logic [11:0] m_frame_height;
    logic [3:0]  m_rate_code;
    logic [2:0]  m_coding_type;

    mpeg_start_code_parser_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_start_code  (m_start_code),
        .m_unit_class  (m_unit_class),
        .m_frame_width (m_frame_width),
        .m_frame_height(m_frame_height),
        .m_rate_code   (m_rate_code),
        .m_coding_type (m_coding_type)
    );

    always #5 aclk = ~aclk;

    stim_row_t   stream_q[$];
    result_t     pending_codes[$];
    int          mismatches = 0;
    bit          quiet = 1'b0;
    logic        cur_typed = 1'b0;
    result_t     cur_want = '0;

    // parser state mirror
    logic [23:0] win_bytes = '0;
    logic [1:0]  win_fill = '0;
    parse_mode_t pmode = MODE_SCAN;
    logic [2:0]  hdr_count = '0;
    logic [31:0] hdr_bytes = '0;
    logic [7:0]  hdr_code = '0;

    // class of a code that reports at once; bit 3 set when known
    function automatic logic [3:0] immediate_class(input logic [7:0] c);
        if (c == CODE_PACK)                         return {1'b1, CLS_PACK};
        if (c == CODE_SYSTEM)                       return {1'b1, CLS_SYSTEM};
        if (c == CODE_GOP)                          return {1'b1, CLS_GOP};
        if (c >= 8'h01 && c <= SLICE_LAST)          return {1'b1, CLS_SLICE};
        if (c >= AUDIO_FIRST && c <= AUDIO_LAST)    return {1'b1, CLS_AUDIO};
        if (c >= VIDEO_FIRST && c <= VIDEO_LAST)    return {1'b1, CLS_VIDEO};
        return 4'd0;
    endfunction

    // advance the mirror by one stream byte, return the start code word if one completes
    task automatic parse_stream_byte(input logic [7:0] b, output bit got, output result_t r);
        logic [3:0] cls;
        got = 1'b0;
        r = '0;
        case (pmode)
            MODE_SEQ: begin
                hdr_bytes = {hdr_bytes[23:0], b};
                hdr_count = hdr_count + 3'd1;
                if (hdr_count >= 3'd4) begin
                    r = mk_word(hdr_code, CLS_SEQUENCE, {hdr_bytes[31:24], hdr_bytes[23:20]},
                                {hdr_bytes[19:16], hdr_bytes[15:8]}, hdr_bytes[3:0], 3'd0);
                    got = 1'b1;
                    pmode = MODE_SCAN;
                    hdr_count = '0;
                    hdr_bytes = '0;
                end
            end
            MODE_PIC: begin
                hdr_bytes = {hdr_bytes[23:0], b};
                hdr_count = hdr_count + 3'd1;
                if (hdr_count >= 3'd2) begin
                    r = mk_word(hdr_code, CLS_PICTURE, 12'd0, 12'd0, 4'd0, b[5:3]);
                    got = 1'b1;
                    pmode = MODE_SCAN;
                    hdr_count = '0;
                    hdr_bytes = '0;
                end
            end
            default: begin
                pmode = MODE_SCAN;
                if (win_fill == WINDOW_FULL && win_bytes == PREFIX_CODE) begin
                    win_bytes = '0;
                    win_fill = '0;
                    hdr_code = b;
                    if (b == CODE_SEQUENCE || b == CODE_PICTURE) begin
                        pmode = (b == CODE_SEQUENCE) ? MODE_SEQ : MODE_PIC;
                        hdr_count = '0;
                        hdr_bytes = '0;
                    end else begin
                        cls = immediate_class(b);
                        if (cls[3]) begin
                            r = mk_word(b, cls[2:0], 12'd0, 12'd0, 4'd0, 3'd0);
                            got = 1'b1;
                        end
                    end
                end else begin
                    win_bytes = {win_bytes[15:0], b};
                    if (win_fill != WINDOW_FULL)
                        win_fill = win_fill + 2'd1;
                end
            end
        endcase
    endtask

    task automatic push_byte(input logic [7:0] b);
        stream_q.push_back('{b, 1'b0, NO_WORD});
    endtask

    task automatic push_prefix();
        push_byte(PREFIX_CODE[23:16]);
        push_byte(PREFIX_CODE[15:8]);
        push_byte(PREFIX_CODE[7:0]);
    endtask

    // one random stream fragment: mostly well-formed units, some noise and broken prefixes
    task automatic add_fragment();
        int kind;
        int k;
        logic [7:0] code;
        kind = $urandom_range(0, 99);
        if (kind < 72) begin
            repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(2, 255)));
            if ($urandom_range(0, 9) == 0)
                push_byte(8'h00);
            push_prefix();
            case ($urandom_range(0, 11))
                0, 1: begin
                    push_byte(CODE_SEQUENCE);
                    repeat (4) push_byte(8'($urandom_range(0, 255)));
                end
                2, 3: begin
                    push_byte(CODE_PICTURE);
                    repeat (2) push_byte(8'($urandom_range(0, 255)));
                end
                4: push_byte(CODE_PACK);
                5: push_byte(CODE_SYSTEM);
                6: push_byte(CODE_GOP);
                7: push_byte(8'($urandom_range(1, SLICE_LAST)));
                8: push_byte(8'($urandom_range(VIDEO_FIRST, VIDEO_LAST)));
                9: push_byte(8'($urandom_range(AUDIO_FIRST, AUDIO_LAST)));
                default: begin
                    // reserved codes above the slice range
                    do
                        code = 8'($urandom_range(8'hB0, 8'hFF));
                    while (immediate_class(code) != 4'd0 || code == CODE_SEQUENCE);
                    push_byte(code);
                end
            endcase
        end else if (kind < 86) begin
            // zero-heavy noise
            repeat ($urandom_range(1, 6)) begin
                k = $urandom_range(0, 9);
                push_byte(k < 4 ? 8'h00 : (k < 5 ? 8'h01 : 8'($urandom_range(0, 255))));
            end
        end else begin
            case ($urandom_range(0, 2))
                0: begin
                    // short prefix
                    push_byte(8'h00);
                    push_byte(8'h01);
                    push_byte(8'($urandom_range(0, 255)));
                end
                1: begin
                    // two zeros then a wrong third byte
                    push_byte(8'h00);
                    push_byte(8'h00);
                    push_byte(8'($urandom_range(2, 255)));
                end
                default: begin
                    // header fields that look like a prefix and code
                    push_prefix();
                    code = $urandom_range(0, 1) ? CODE_SEQUENCE : CODE_PICTURE;
                    push_byte(code);
                    push_prefix();
                    push_byte(CODE_PACK);
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // prediction at the accepting edge, then compare of the result word
    result_t predicted;
    result_t oldest;
    bit      predicted_any;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                parse_stream_byte(s_data_byte, predicted_any, predicted);
                if (cur_typed)
                    pending_codes.push_back(cur_want);
                else if (predicted_any)
                    pending_codes.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (pending_codes.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none actual code %0h class %0d",
                             $time, m_start_code, m_unit_class);
                end else begin
                    oldest = pending_codes.pop_front();
                    check_field("start_code", 12'(oldest.start_code), 12'(m_start_code));
                    check_field("unit_class", 12'(oldest.unit_class), 12'(m_unit_class));
                    check_field("frame_width", oldest.frame_width, m_frame_width);
                    check_field("frame_height", oldest.frame_height, m_frame_height);
                    check_field("rate_code", 12'(oldest.rate_code), 12'(m_rate_code));
                    check_field("coding_type", 12'(oldest.coding_type), 12'(m_coding_type));
                end
            end
        end
    end

    // result side back-pressure in bursts, with the stall rate picked anew for each span
    initial begin : sink_stalls
        int stall;
        int pct;
        int span;
        stall = 0;
        pct = 0;
        span = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (span == 0) begin
                span = 64;
                case ($urandom_range(0, 2))
                    0:       pct = 0;
                    1:       pct = 8;
                    default: pct = 30;
                endcase
            end
            span--;
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < pct) begin
                stall = $urandom_range(0, 12);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // reset, stream generation and byte driver
    initial begin : byte_driver
        int i;
        int n;
        int gap;
        int pct;
        bit drain;
        pct = 0;
        foreach (DIRECTED[j])
            stream_q.push_back(DIRECTED[j]);
        while (stream_q.size() < DIR_ROWS + RAND_BYTES)
            add_fragment();
        n = stream_q.size();

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       pct = 0;
                    1:       pct = 6;
                    default: pct = 30;
                endcase
            end
            quiet = (i >= n - QUIET_ROWS);
            drain = (i == DIR_ROWS || i == n / 2);
            gap = (!quiet && $urandom_range(0, 99) < pct) ? $urandom_range(1, 13) : 0;
            if (drain || gap > 0) begin
                s_valid <= 1'b0;
                @(negedge aclk);
                while (drain && pending_codes.size() != 0)
                    @(negedge aclk);
                if (gap > 1)
                    repeat (gap - 1) @(negedge aclk);
            end
            s_valid <= 1'b1;
            s_data_byte <= stream_q[i].data;
            cur_typed = stream_q[i].typed;
            cur_want = stream_q[i].want;
            do
                @(posedge aclk);
            while (!s_ready);
            @(negedge aclk);
        end
        s_valid <= 1'b0;

        while (pending_codes.size() != 0)
            @(negedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("tb failed");
        $finish;
    end

endmodule

>>> files.f
design/mscp_pkg.sv
design/mpeg_start_code_parser_unit.sv
tb/tb.sv
